// File: sv/cfc_pkg.sv
// Shared types, constants and the CRC-32C byte update for the frame checker.
// No dependencies; imported by cfc_regs, crc32c_frame_checker_core, cfc_tb_pkg and tb_top.
package cfc_pkg;

	// Frame layout, offsets within the header
	localparam int HEADER_BYTES  = 28;
	localparam int TRAILER_BYTES = 4;
	localparam int OFS_VERSION   = 4;
	localparam int OFS_TYPE      = 6;
	localparam int OFS_FLAGS     = 8;
	localparam int OFS_CORR      = 12;
	localparam int OFS_LENGTH    = 20;
	localparam int OFS_HCRC      = 24;

	localparam int POS_W = 34;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Register map, word index on paddr[4:2]
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_MAGIC       = 3'd0;
	localparam logic [2:0] REG_VERSION     = 3'd1;
	localparam logic [2:0] REG_TYPE_LOWEST = 3'd2;
	localparam logic [2:0] REG_TYPE_LIMIT  = 3'd3;
	localparam logic [2:0] REG_MAX_PAYLOAD = 3'd4;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_SHORT       = 4'd1,
		ST_MAGIC       = 4'd2,
		ST_VERSION     = 4'd3,
		ST_TYPE        = 4'd4,
		ST_TOO_LONG    = 4'd5,
		ST_LEN_MISMATCH = 4'd6,
		ST_HEADER_CRC  = 4'd7,
		ST_PAYLOAD_CRC = 4'd8
	} status_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [15:0] expected_version;
		logic [15:0] type_lowest;
		logic [15:0] type_limit;
		logic [31:0] max_payload;
	} cfg_t;

	// Reflected CRC-32C, one byte folded in, bit at a time
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: sv/cfc_regs.sv
// Configuration register file behind the APB-style port.
// Depends on cfc_pkg for the register map and the cfg_t bundle.
module cfc_regs import cfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output cfg_t              cfg
);

	logic       wr_en;
	logic [2:0] widx;

	assign wr_en = psel && penable && pwrite;
	assign widx  = paddr[ADDR_W-1:2];

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.magic_word       <= 32'd0;
			cfg.expected_version <= 16'd1;
			cfg.type_lowest      <= 16'd0;
			cfg.type_limit       <= 16'd24;
			cfg.max_payload      <= 32'd1048576;
		end else if (wr_en) begin
			unique case (widx)
				REG_MAGIC:       cfg.magic_word       <= pwdata;
				REG_VERSION:     cfg.expected_version <= pwdata[15:0];
				REG_TYPE_LOWEST: cfg.type_lowest      <= pwdata[15:0];
				REG_TYPE_LIMIT:  cfg.type_limit       <= pwdata[15:0];
				REG_MAX_PAYLOAD: cfg.max_payload      <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (widx)
			REG_MAGIC:       prdata = cfg.magic_word;
			REG_VERSION:     prdata = {16'd0, cfg.expected_version};
			REG_TYPE_LOWEST: prdata = {16'd0, cfg.type_lowest};
			REG_TYPE_LIMIT:  prdata = {16'd0, cfg.type_limit};
			REG_MAX_PAYLOAD: prdata = cfg.max_payload;
			default:         prdata = 32'd0;
		endcase
	end

endmodule

// File: sv/crc32c_frame_checker_core.sv
// CRC-32C frame checker: header decode, payload pass-through, end-of-frame status.
// Depends on cfc_pkg and cfc_regs.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------------
//   in      | sink      | in_valid / in_stall    | data_byte, frame_end
//   out     | source    | out_valid / out_stall  | kind, payload_byte, status, message_type,
//           |           |                        | frame_flags, correlation, payload_length
//   cfg     | sink      | psel/penable/pready    | paddr, pwdata, prdata
//
// One byte per cycle sustained while the result register is not stalled. A beat lands in the
// input register, then a single pass of CRC update, field capture and checks fills
// the result register. Reset clears frame state and loads register defaults.
// in_stall rises only when the input register holds a beat and the result register
// is full and stalled; a beat that yields no result still needs the result slot free.
module crc32c_frame_checker_core import cfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              frame_end,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [7:0]        payload_byte,
	output logic [3:0]        status,
	output logic [15:0]       message_type,
	output logic [31:0]       frame_flags,
	output logic [63:0]       correlation,
	output logic [31:0]       payload_length,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg;

	cfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       adv;

	// Frame state
	logic [POS_W-1:0] pos_q;
	logic [31:0]      hcrc_run_q, pcrc_run_q;
	logic [31:0]      magic_q, flags_q, length_q, hcrc_q, trailer_q;
	logic [15:0]      version_q, type_q;
	logic [63:0]      corr_q;

	logic [31:0]      hcrc_run_nx, pcrc_run_nx;
	logic [31:0]      magic_nx, flags_nx, length_nx, hcrc_nx, trailer_nx;
	logic [15:0]      version_nx, type_nx;
	logic [63:0]      corr_nx;

	logic [4:0]       k;
	logic             in_hdr, is_payload, in_trailer;
	logic [POS_W-1:0] pend, tend, toff;
	logic [POS_W:0]   total, expect_len;
	status_t          stat;
	logic             emit;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// Load a new beat whenever the input register is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

	// Locate the byte within the frame
	assign k          = pos_q[4:0];
	assign in_hdr     = (pos_q < POS_W'(HEADER_BYTES));
	assign pend       = POS_W'(HEADER_BYTES) + {{(POS_W-32){1'b0}}, length_q};
	assign tend       = pend + POS_W'(TRAILER_BYTES);
	assign is_payload = !in_hdr && (pos_q < pend);
	assign in_trailer = !in_hdr && !is_payload && (pos_q < tend);
	assign toff       = pos_q - pend;

	// Capture header fields, trailer and running CRCs
	always_comb begin
		hcrc_run_nx = hcrc_run_q;
		pcrc_run_nx = pcrc_run_q;
		magic_nx    = magic_q;
		version_nx  = version_q;
		type_nx     = type_q;
		flags_nx    = flags_q;
		corr_nx     = corr_q;
		length_nx   = length_q;
		hcrc_nx     = hcrc_q;
		trailer_nx  = trailer_q;
		if (in_hdr) begin
			if (k < 5'(OFS_HCRC)) begin
				hcrc_run_nx = crc32c_byte(hcrc_run_q, byte_s1);
			end
			if (k < 5'(OFS_VERSION)) begin
				magic_nx[{k[1:0], 3'b000} +: 8] = byte_s1;
			end else if (k < 5'(OFS_TYPE)) begin
				version_nx[{k[0], 3'b000} +: 8] = byte_s1;
			end else if (k < 5'(OFS_FLAGS)) begin
				type_nx[{k[0], 3'b000} +: 8] = byte_s1;
			end else if (k < 5'(OFS_CORR)) begin
				flags_nx[{k[1:0], 3'b000} +: 8] = byte_s1;
			end else if (k < 5'(OFS_LENGTH)) begin
				corr_nx[{3'(k - 5'(OFS_CORR)), 3'b000} +: 8] = byte_s1;
			end else if (k < 5'(OFS_HCRC)) begin
				length_nx[{k[1:0], 3'b000} +: 8] = byte_s1;
			end else begin
				hcrc_nx[{k[1:0], 3'b000} +: 8] = byte_s1;
			end
		end else if (is_payload) begin
			pcrc_run_nx = crc32c_byte(pcrc_run_q, byte_s1);
		end else if (in_trailer) begin
			trailer_nx[{toff[1:0], 3'b000} +: 8] = byte_s1;
		end
	end

	// Checks in priority order, on the state after this byte
	assign total      = {1'b0, pos_q} + (POS_W+1)'(1);
	assign expect_len = (POS_W+1)'(HEADER_BYTES + TRAILER_BYTES)
		+ {{(POS_W-31){1'b0}}, length_nx};

	always_comb begin
		if (total < (POS_W+1)'(HEADER_BYTES + TRAILER_BYTES)) begin
			stat = ST_SHORT;
		end else if (magic_nx != cfg.magic_word) begin
			stat = ST_MAGIC;
		end else if (version_nx != cfg.expected_version) begin
			stat = ST_VERSION;
		end else if (type_nx < cfg.type_lowest || type_nx >= cfg.type_limit) begin
			stat = ST_TYPE;
		end else if (length_nx > cfg.max_payload) begin
			stat = ST_TOO_LONG;
		end else if (total != expect_len) begin
			stat = ST_LEN_MISMATCH;
		end else if (~hcrc_run_nx != hcrc_nx) begin
			stat = ST_HEADER_CRC;
		end else if (~pcrc_run_nx != trailer_nx) begin
			stat = ST_PAYLOAD_CRC;
		end else begin
			stat = ST_OK;
		end
	end

	assign emit = end_s1 || is_payload;

	// Advance frame state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hcrc_run_q <= CRC_INIT;
			pcrc_run_q <= CRC_INIT;
			magic_q    <= '0;
			version_q  <= '0;
			type_q     <= '0;
			flags_q    <= '0;
			corr_q     <= '0;
			length_q   <= '0;
			hcrc_q     <= '0;
			trailer_q  <= '0;
		end else if (adv) begin
			if (end_s1) begin
				pos_q      <= '0;
				hcrc_run_q <= CRC_INIT;
				pcrc_run_q <= CRC_INIT;
				magic_q    <= '0;
				version_q  <= '0;
				type_q     <= '0;
				flags_q    <= '0;
				corr_q     <= '0;
				length_q   <= '0;
				hcrc_q     <= '0;
				trailer_q  <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				hcrc_run_q <= hcrc_run_nx;
				pcrc_run_q <= pcrc_run_nx;
				magic_q    <= magic_nx;
				version_q  <= version_nx;
				type_q     <= type_nx;
				flags_q    <= flags_nx;
				corr_q     <= corr_nx;
				length_q   <= length_nx;
				hcrc_q     <= hcrc_nx;
				trailer_q  <= trailer_nx;
			end
		end
	end

	// Result register: load on advance, empty for a beat with no result; drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= emit;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			if (end_s1) begin
				kind           <= 1'b1;
				payload_byte   <= 8'd0;
				status         <= stat;
				message_type   <= type_nx;
				frame_flags    <= flags_nx;
				correlation    <= corr_nx;
				payload_length <= length_nx;
			end else begin
				kind           <= 1'b0;
				payload_byte   <= byte_s1;
				status         <= ST_OK;
				message_type   <= '0;
				frame_flags    <= '0;
				correlation    <= '0;
				payload_length <= '0;
			end
		end
	end

	// Checks on the block's own control
	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked beat");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(byte_s1) && $stable(end_s1)))
		else $error("input register changed while stalled");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && end_s1) |=> (pos_q == '0 && hcrc_run_q == CRC_INIT))
		else $error("frame state not cleared after final byte");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (status == ST_OK && payload_length == 32'd0))
		else $error("payload result carries status fields");

	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> (payload_byte == 8'd0))
		else $error("status result carries a payload byte");

endmodule

// File: verif/cfc_tb_pkg.sv
// Scoreboard for the frame checker testbench: result beat type, CRC-32C step
// and a frame predictor with its queue of awaited result beats. Depends on cfc_pkg.
package cfc_tb_pkg;
	import cfc_pkg::*;

	// One result beat, packed in port order
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [3:0]  status;
		logic [15:0] message_type;
		logic [31:0] frame_flags;
		logic [63:0] correlation;
		logic [31:0] payload_length;
	} frame_beat_t;

	// Reflected CRC-32C, data bit fed into the low end each step
	function automatic logic [31:0] crc32c_next(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ b[i]}});
		end
		return c;
	endfunction

	class frame_scoreboard;
		// register copies
		logic [31:0] magic_word;
		logic [15:0] expected_version;
		logic [15:0] type_lowest;
		logic [15:0] type_limit;
		logic [31:0] max_payload;

		// frame under way
		logic [POS_W-1:0] position;
		logic [31:0] hdr_crc, body_crc;
		logic [31:0] magic_got, flags_got, length_got, hcrc_got, trailer_got;
		logic [15:0] version_got, type_got;
		logic [63:0] corr_got;

		frame_beat_t pending[$];
		int errors;
		int beats_checked;
		int frames_closed;
		int status_count[9];

		function new();
			magic_word       = 32'd0;
			expected_version = 16'd1;
			type_lowest      = 16'd0;
			type_limit       = 16'd24;
			max_payload      = 32'd1048576;
			errors        = 0;
			beats_checked = 0;
			frames_closed = 0;
			foreach (status_count[i]) status_count[i] = 0;
			restart_frame();
		endfunction

		function void set_reg(input logic [2:0] idx, input logic [31:0] value);
			case (idx)
				REG_MAGIC:       magic_word       = value;
				REG_VERSION:     expected_version = value[15:0];
				REG_TYPE_LOWEST: type_lowest      = value[15:0];
				REG_TYPE_LIMIT:  type_limit       = value[15:0];
				REG_MAX_PAYLOAD: max_payload      = value;
				default: ;
			endcase
		endfunction

		function void restart_frame();
			position    = '0;
			hdr_crc     = CRC_INIT;
			body_crc    = CRC_INIT;
			magic_got   = '0;
			version_got = '0;
			type_got    = '0;
			flags_got   = '0;
			corr_got    = '0;
			length_got  = '0;
			hcrc_got    = '0;
			trailer_got = '0;
		endfunction

		// First failing check, in the block's check order
		function status_t frame_status();
			logic [63:0] total, want;
			total = 64'(position) + 64'd1;
			want  = 64'(HEADER_BYTES) + 64'(length_got) + 64'(TRAILER_BYTES);
			if (total < 64'(HEADER_BYTES + TRAILER_BYTES)) return ST_SHORT;
			if (magic_got != magic_word) return ST_MAGIC;
			if (version_got != expected_version) return ST_VERSION;
			if (type_got < type_lowest || type_got >= type_limit) return ST_TYPE;
			if (length_got > max_payload) return ST_TOO_LONG;
			if (total != want) return ST_LEN_MISMATCH;
			if (~hdr_crc != hcrc_got) return ST_HEADER_CRC;
			if (~body_crc != trailer_got) return ST_PAYLOAD_CRC;
			return ST_OK;
		endfunction

		// Advance the predicted frame by one accepted input beat
		function void note_input(input logic [7:0] b, input logic last);
			frame_beat_t r;
			int k;
			logic [63:0] body_end;
			bit is_body;
			r = '0;
			is_body = 1'b0;
			if (position < HEADER_BYTES) begin
				k = int'(position);
				if (k < OFS_HCRC) hdr_crc = crc32c_next(hdr_crc, b);
				if (k < OFS_VERSION) magic_got[8*k +: 8] = b;
				else if (k < OFS_TYPE) version_got[8*(k-OFS_VERSION) +: 8] = b;
				else if (k < OFS_FLAGS) type_got[8*(k-OFS_TYPE) +: 8] = b;
				else if (k < OFS_CORR) flags_got[8*(k-OFS_FLAGS) +: 8] = b;
				else if (k < OFS_LENGTH) corr_got[8*(k-OFS_CORR) +: 8] = b;
				else if (k < OFS_HCRC) length_got[8*(k-OFS_LENGTH) +: 8] = b;
				else hcrc_got[8*(k-OFS_HCRC) +: 8] = b;
			end else begin
				body_end = 64'(HEADER_BYTES) + 64'(length_got);
				if (64'(position) < body_end) begin
					body_crc = crc32c_next(body_crc, b);
					is_body = 1'b1;
				end else if (64'(position) < body_end + 64'(TRAILER_BYTES)) begin
					trailer_got[8*int'(64'(position) - body_end) +: 8] = b;
				end
			end

			// the final byte closes the frame with a status beat only
			if (last) begin
				r.kind           = 1'b1;
				r.status         = frame_status();
				r.message_type   = type_got;
				r.frame_flags    = flags_got;
				r.correlation    = corr_got;
				r.payload_length = length_got;
				pending.insert(pending.size(), r);
				restart_frame();
				return;
			end

			if (position != POS_MAX) position++;
			if (is_body) begin
				r.payload_byte = b;
				pending.insert(pending.size(), r);
			end
		endfunction

		function void field_check(input string name, input logic [63:0] want,
				input logic [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		// Compare an accepted result beat with the oldest awaited one
		function void check_result(input frame_beat_t got);
			frame_beat_t want;
			if (pending.size() == 0) begin
				$error("result beat with none awaited: kind %0h status %0h", got.kind, got.status);
				errors++;
				return;
			end
			want = pending.pop_front();
			beats_checked++;
			if (want.kind) begin
				frames_closed++;
				status_count[want.status]++;
			end
			field_check("kind", 64'(want.kind), 64'(got.kind));
			field_check("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
			field_check("status", 64'(want.status), 64'(got.status));
			field_check("message_type", 64'(want.message_type), 64'(got.message_type));
			field_check("frame_flags", 64'(want.frame_flags), 64'(got.frame_flags));
			field_check("correlation", want.correlation, got.correlation);
			field_check("payload_length", 64'(want.payload_length), 64'(got.payload_length));
		endfunction

		function string status_summary();
			string s;
			status_t st;
			s = "";
			foreach (status_count[i]) begin
				st = status_t'(i);
				s = {s, $sformatf(" %s=%0d", st.name(), status_count[i])};
			end
			return s;
		endfunction
	endclass

endpackage

// File: verif/tb_top.sv
// Top-level testbench for crc32c_frame_checker_core: builds frames, drives the byte
// channel and the APB port, checks every result beat. Depends on cfc_pkg, cfc_tb_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cfc_pkg::*;
	import cfc_tb_pkg::*;

	// Cycles with no beat accepted on either channel before giving up. The longest
	// correct quiet stretch is a drain plus a register update.
	localparam int QUIET_LIMIT = 5000;

	typedef enum int {
		FLAW_NONE,
		FLAW_NOISE,
		FLAW_MAGIC,
		FLAW_VERSION,
		FLAW_TYPE,
		FLAW_TOO_LONG,
		FLAW_CUT,
		FLAW_EXTRA,
		FLAW_HCRC,
		FLAW_PCRC
	} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [3:0]  status;
	logic [15:0] message_type;
	logic [31:0] frame_flags;
	logic [63:0] correlation;
	logic [31:0] payload_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	frame_scoreboard sb = new();
	logic [7:0] frame_q[$];
	bit calm = 1'b0;
	int bytes_sent = 0;
	int quiet = 0;
	int target;
	logic [15:0] lo_type;

	crc32c_frame_checker_core dut (.*);

	initial forever #5 clk = ~clk;

	// Present one input beat and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic last);
		// idle only before the beat goes up, never while it is stalled
		while (!calm && $urandom_range(99, 0) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		frame_end <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++) begin
			send_byte(frame_q[i], i == frame_q.size() - 1);
		end
	endtask

	// Drop valid and hold off until every awaited beat is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write, then read back the same register
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == REG_MAGIC || idx == REG_MAX_PAYLOAD) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (value & mask)) begin
			$error("register %0d readback mismatch: expected %0h, actual %0h",
				idx, value & mask, prdata & mask);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_all(input logic [31:0] mg, input logic [15:0] ver,
			input logic [15:0] lo, input logic [15:0] lim, input logic [31:0] mx);
		cfg_write(REG_MAGIC, mg);
		cfg_write(REG_VERSION, {16'd0, ver});
		cfg_write(REG_TYPE_LOWEST, {16'd0, lo});
		cfg_write(REG_TYPE_LIMIT, {16'd0, lim});
		cfg_write(REG_MAX_PAYLOAD, mx);
	endtask

	task automatic put_le(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) frame_q.insert(frame_q.size(), v[8*i +: 8]);
	endtask

	// Assemble header, header CRC, random payload and payload CRC into frame_q
	task automatic build_frame(input logic [31:0] mg, input logic [15:0] ver,
			input logic [15:0] ty, input logic [31:0] fl, input logic [63:0] co,
			input logic [31:0] len, input int body);
		logic [31:0] c;
		logic [7:0] b;
		frame_q.delete();
		put_le(64'(mg), 4);
		put_le(64'(ver), 2);
		put_le(64'(ty), 2);
		put_le(64'(fl), 4);
		put_le(co, 8);
		put_le(64'(len), 4);
		c = CRC_INIT;
		for (int i = 0; i < OFS_HCRC; i++) c = crc32c_next(c, frame_q[i]);
		put_le(64'(~c), 4);
		c = CRC_INIT;
		for (int i = 0; i < body; i++) begin
			b = 8'($urandom);
			frame_q.insert(frame_q.size(), b);
			c = crc32c_next(c, b);
		end
		put_le(64'(~c), 4);
	endtask

	task automatic cut_frame(input int n);
		while (frame_q.size() > n) void'(frame_q.pop_back());
	endtask

	// One random frame against the current register values, mostly well formed
	task automatic random_frame();
		logic [31:0] mg, fl, len, mx;
		logic [15:0] ver, ty;
		logic [63:0] co;
		int body, at;
		flaw_t flaw;
		mg  = sb.magic_word;
		ver = sb.expected_version;
		ty  = 16'($urandom_range(int'(sb.type_limit) - 1, int'(sb.type_lowest)));
		fl  = $urandom;
		co  = {$urandom, $urandom};
		mx  = sb.max_payload;
		len = $urandom_range((mx < 12) ? mx : 12, 0);
		if ($urandom_range(19, 0) == 0) len = $urandom_range((mx < 48) ? mx : 48, 0);
		body = int'(len);
		flaw = ($urandom_range(99, 0) < 70) ? FLAW_NONE : flaw_t'($urandom_range(9, 1));
		case (flaw)
			FLAW_MAGIC:   mg  = mg ^ (32'd1 << $urandom_range(31, 0));
			FLAW_VERSION: ver = ver ^ (16'd1 << $urandom_range(15, 0));
			FLAW_TYPE: begin
				if (sb.type_lowest != 0 && $urandom_range(1, 0) == 1)
					ty = 16'($urandom_range(int'(sb.type_lowest) - 1, 0));
				else
					ty = 16'($urandom_range(16'hFFFF, int'(sb.type_limit)));
			end
			FLAW_TOO_LONG: begin
				len  = (mx == 32'hFFFF_FFFF) ? mx : mx + 32'd1;
				body = $urandom_range(3, 0);
			end
			default: ;
		endcase
		build_frame(mg, ver, ty, fl, co, len, body);
		case (flaw)
			FLAW_NOISE: begin
				frame_q.delete();
				repeat ($urandom_range(40, 1)) frame_q.insert(frame_q.size(), 8'($urandom));
			end
			FLAW_CUT:   cut_frame($urandom_range(frame_q.size() - 1, 1));
			FLAW_EXTRA: repeat ($urandom_range(6, 1)) frame_q.insert(frame_q.size(), 8'($urandom));
			FLAW_HCRC: begin
				at = $urandom_range(OFS_HCRC + 3, OFS_HCRC);
				frame_q[at] = frame_q[at] ^ (8'd1 << $urandom_range(7, 0));
			end
			FLAW_PCRC: begin
				at = $urandom_range(frame_q.size() - 1, HEADER_BYTES);
				frame_q[at] = frame_q[at] ^ (8'd1 << $urandom_range(7, 0));
			end
			default: ;
		endcase
		send_frame();
	endtask

	// Receiver: stall at random, check each accepted result beat
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({kind, payload_byte, status, message_type, frame_flags,
				correlation, payload_length});
		out_stall <= !calm && ($urandom_range(99, 0) < 31);
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("no beat accepted for %0d cycles", quiet);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: good frames, then at least one frame per failing check
		build_frame(32'd0, 16'd1, 16'd0, 32'd0, 64'd0, 32'd0, 0);
		send_frame();
		build_frame(32'd0, 16'd1, 16'd23, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd6, 6);
		send_frame();
		frame_q.delete();
		frame_q.insert(frame_q.size(), 8'hFF);
		send_frame();
		build_frame(32'd0, 16'd1, 16'd3, $urandom, {$urandom, $urandom}, 32'd0, 0);
		cut_frame(HEADER_BYTES + TRAILER_BYTES - 1);
		send_frame();
		build_frame(32'd1, 16'd1, 16'd0, $urandom, {$urandom, $urandom}, 32'd1, 1);
		send_frame();
		build_frame(32'd0, 16'd0, 16'd0, $urandom, {$urandom, $urandom}, 32'd1, 1);
		send_frame();
		build_frame(32'd0, 16'd1, 16'd24, $urandom, {$urandom, $urandom}, 32'd0, 0);
		send_frame();
		build_frame(32'd0, 16'd1, 16'd5, $urandom, {$urandom, $urandom}, 32'd1048577, 0);
		send_frame();
		// frame ends inside the payload window
		build_frame(32'd0, 16'd1, 16'd7, $urandom, {$urandom, $urandom}, 32'd10, 10);
		cut_frame(HEADER_BYTES + 5);
		send_frame();
		// bytes run on past the trailer
		build_frame(32'd0, 16'd1, 16'd7, $urandom, {$urandom, $urandom}, 32'd2, 2);
		repeat (3) frame_q.insert(frame_q.size(), 8'($urandom));
		send_frame();
		build_frame(32'd0, 16'd1, 16'd9, $urandom, {$urandom, $urandom}, 32'd2, 2);
		frame_q[OFS_HCRC + 1] = frame_q[OFS_HCRC + 1] ^ 8'h01;
		send_frame();
		build_frame(32'd0, 16'd1, 16'd9, $urandom, {$urandom, $urandom}, 32'd3, 3);
		frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'h80;
		send_frame();

		// Magic, version and type limit at their top values, type window 0x10 to 0xFFFE, no payload allowed
		drain();
		cfg_all(32'hFFFF_FFFF, 16'hFFFF, 16'h0010, 16'hFFFF, 32'd0);
		build_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h0010, $urandom, 64'd0, 32'd0, 0);
		send_frame();
		build_frame(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE, $urandom, 64'd0, 32'd0, 0);
		send_frame();
		build_frame(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, $urandom, 64'd0, 32'd0, 0);
		send_frame();
		build_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h000F, $urandom, 64'd0, 32'd0, 0);
		send_frame();
		build_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h0100, $urandom, 64'd0, 32'd1, 1);
		send_frame();
		build_frame(32'hFFFF_FFFF, 16'h0000, 16'h0100, $urandom, 64'd0, 32'd0, 0);
		send_frame();

		// Empty type window, then widest length with a huge declared payload
		drain();
		cfg_all(32'hA5C3_0F96, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
		build_frame(32'hA5C3_0F96, 16'd0, 16'd0, $urandom, {$urandom, $urandom}, 32'd0, 0);
		send_frame();
		drain();
		cfg_write(REG_TYPE_LIMIT, 32'h0000_FFFF);
		build_frame(32'hA5C3_0F96, 16'd0, 16'd0, $urandom, {$urandom, $urandom},
			32'hFFFF_FFFF, 1);
		send_frame();
		build_frame(32'hA5C3_0F96, 16'd0, 16'hFFFE, $urandom, {$urandom, $urandom}, 32'd4, 4);
		send_frame();

		// Random phases, each with fresh register values; one phase never idles
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			lo_type = 16'($urandom_range(16'hFFF0, 0));
			cfg_all($urandom, 16'($urandom), lo_type,
				16'($urandom_range(16'hFFFF, int'(lo_type) + 1)),
				($urandom_range(1, 0) == 1) ? $urandom : $urandom_range(20, 0));
			calm = (ph == 2);
			target = bytes_sent + ((ph == 2) ? 80 : 15);
			while (bytes_sent < target) begin
				random_frame();
				if ($urandom_range(7, 0) == 0) drain();
			end
		end
		calm = 1'b0;

		drain();
		$display("checked %0d result beats over %0d frames from %0d input bytes",
			sb.beats_checked, sb.frames_closed, bytes_sent);
		$display("end-of-frame statuses:%s", sb.status_summary());
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
